// ===== rtl/jdcal_pkg.sv =====
// shared constants, control types and lookup functions for the julian day converter
package jdcal_pkg;

   // field widths
   localparam int JDN_W   = 23;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int ORD_W   = 9;

   // pipeline depth
   localparam int NSTAGE = 9;

   // supported span and calendar switch
   localparam logic [JDN_W-1:0] JDN_LOW    = 23'd1721424;
   localparam logic [JDN_W-1:0] JDN_HIGH   = 23'd5373484;
   localparam logic [JDN_W-1:0] GREG_START = 23'd2299161;

   // scaled algorithm offsets
   localparam logic [24:0] ALPHA_OFS = 25'd7468865;
   localparam logic [26:0] C_OFS     = 27'd2442;
   localparam logic [22:0] B_OFS     = 23'd1524;

   // reciprocal multipliers: q = (x * ceil(2^S / d)) >> S, exact over the used span
   localparam int ALPHA_SH = 42;
   localparam logic [24:0] ALPHA_MUL =
      25'(((64'd1 << ALPHA_SH) + 64'd146096) / 64'd146097);

   localparam int C_SH = 40;
   localparam logic [27:0] C_MUL =
      28'(((64'd1 << C_SH) + 64'd7304) / 64'd7305);

   // month code divisor folded with the 10000 scale of the numerator
   localparam int E_SH = 43;
   localparam logic [38:0] E_MUL =
      39'((((64'd1 << E_SH) + 64'd306000) / 64'd306001) * 64'd10000);

   localparam int W_SH = 27;
   localparam logic [24:0] W_MUL =
      25'(((64'd1 << W_SH) + 64'd6) / 64'd7);

   localparam int Y_SH = 19;
   localparam logic [14:0] Y_MUL =
      15'(((64'd1 << Y_SH) + 64'd24) / 64'd25);

   // pipeline control between the handshake logic and the datapath
   typedef struct packed {
      logic [NSTAGE-1:0] load;
      logic [NSTAGE-1:0] valid;
   } pipe_ctl_type;

   // floor(30.6001 * e) for the month code
   function automatic logic [8:0] e_offset(input logic [3:0] e);
      logic [8:0] r;
      case (e)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd30;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd91;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd183;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd244;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd336;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd397;
         4'd14:   r = 9'd428;
         4'd15:   r = 9'd459;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // days in the common year before the given month
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/jdcal_if.sv =====
// valid/ready channel interfaces for day numbers in and calendar dates out
interface jdcal_req_if import jdcal_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [JDN_W-1:0] julian_day_number;

   modport source (output valid, output julian_day_number, input ready);
   modport sink   (input valid, input julian_day_number, output ready);
endinterface

interface jdcal_rsp_if import jdcal_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  cal_year;
   logic [MONTH_W-1:0] cal_month;
   logic [DAY_W-1:0]   cal_day;
   logic [WDAY_W-1:0]  weekday;
   logic [ORD_W-1:0]   ordinal_day;
   logic               range_error;

   modport source (output valid, output cal_year, output cal_month, output cal_day,
                   output weekday, output ordinal_day, output range_error, input ready);
   modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                   input weekday, input ordinal_day, input range_error, output ready);
endinterface

// ===== rtl/jdcal_pipe_ctl.sv =====
// valid bits and per-stage load enables of the converter pipeline, bubbles collapse
module jdcal_pipe_ctl import jdcal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic         out_ready,
   output pipe_ctl_type ctl
);

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] load;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      load[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

endmodule

// ===== rtl/julian_day_to_calendar_date.sv =====
// Julian day number to calendar date converter. Each item is one integer Julian day
// number; the result gives year, month and day (Julian calendar before day 2299161,
// Gregorian from then on), the weekday (0 is Sunday), the day of the year with the
// Gregorian leap rule, and a range flag for numbers outside 1721424..5373484, in which
// case every other field is zero. The converter is a nine-stage pipeline that takes one
// item every clock while it has room (a stalled output with every stage full holds the
// input); each item passes through stage registers 0 to 8 in order and its result is
// presented from the stage 8 register. The depth is set by the chain of constant divisions
// (done as reciprocal multiplies), each followed by a register. A stalled output holds the
// pipeline while empty stages still fill, so up to nine items can be in flight.
module julian_day_to_calendar_date import jdcal_pkg::*; (
   input logic          clock,
   input logic          reset,
   jdcal_req_if.sink    req_chan,
   jdcal_rsp_if.source  rsp_chan
);

   pipe_ctl_type ctl;

   // stage 0: range check, gregorian select, alpha numerator
   logic [JDN_W-1:0] z0_ff;
   logic             err0_ff, greg0_ff;
   logic [23:0]      xa0_ff;
   logic [JDN_W-1:0] z0_in;
   logic             err0_in, greg0_in;
   logic [23:0]      xa0_in;

   // stage 1: alpha product
   logic [JDN_W-1:0] z1_ff;
   logic             err1_ff, greg1_ff;
   logic [48:0]      pa1_ff;
   logic [48:0]      pa1_in;

   // stage 2: b, c numerator, weekday product
   logic [6:0]       alpha2;
   logic [JDN_W-1:0] a2;
   logic [22:0]      b2_ff, b2_in;
   logic [26:0]      xc2_ff, xc2_in;
   logic [23:0]      w2_ff, w2_in;
   logic [48:0]      pw2_ff, pw2_in;
   logic             err2_ff;

   // stage 3: c product
   logic [22:0]      b3_ff;
   logic [54:0]      pc3_ff, pc3_in;
   logic [23:0]      w3_ff;
   logic [48:0]      pw3_ff;
   logic             err3_ff;

   // stage 4: c, b - d, weekday remainder
   logic [14:0]      c4_ff, c4_in;
   logic [22:0]      d4;
   logic [9:0]       bd4_ff, bd4_in;
   logic [21:0]      wq4;
   logic [WDAY_W-1:0] wd4_ff, wd4_in;
   logic             err4_ff;

   // stage 5: month code product
   logic [14:0]      c5_ff;
   logic [9:0]       bd5_ff;
   logic [48:0]      pe5_ff, pe5_in;
   logic [WDAY_W-1:0] wd5_ff;
   logic             err5_ff;

   // stage 6: year, month, day
   logic [3:0]         e6;
   logic [9:0]         day6;
   logic [YEAR_W-1:0]  year6_ff, year6_in;
   logic [MONTH_W-1:0] month6_ff, month6_in;
   logic [DAY_W-1:0]   day6_ff, day6_in;
   logic [WDAY_W-1:0]  wd6_ff;
   logic               err6_ff;

   // stage 7: century test product
   logic [YEAR_W-1:0]  year7_ff;
   logic [MONTH_W-1:0] month7_ff;
   logic [DAY_W-1:0]   day7_ff;
   logic [WDAY_W-1:0]  wd7_ff;
   logic [28:0]        py7_ff, py7_in;
   logic               err7_ff;

   // stage 8: leap rule, ordinal day, output register
   logic [9:0]         q25_8;
   logic               div25_8, leap8;
   logic [ORD_W-1:0]   ord8;
   logic [YEAR_W-1:0]  year8_ff, year8_in;
   logic [MONTH_W-1:0] month8_ff, month8_in;
   logic [DAY_W-1:0]   day8_ff, day8_in;
   logic [WDAY_W-1:0]  wd8_ff, wd8_in;
   logic [ORD_W-1:0]   ord8_ff, ord8_in;
   logic               err8_ff;

   // handshake and stage enables
   jdcal_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // stage 0 logic
   always_comb begin
      z0_in    = req_chan.julian_day_number;
      err0_in  = (z0_in < JDN_LOW) || (z0_in > JDN_HIGH);
      greg0_in = (z0_in >= GREG_START);
      xa0_in   = greg0_in ? 24'({z0_in, 2'b00} - ALPHA_OFS) : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         z0_ff    <= z0_in;
         err0_ff  <= err0_in;
         greg0_ff <= greg0_in;
         xa0_ff   <= xa0_in;
      end
   end

   // stage 1 logic
   assign pa1_in = 49'(xa0_ff) * 49'(ALPHA_MUL);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         z1_ff    <= z0_ff;
         err1_ff  <= err0_ff;
         greg1_ff <= greg0_ff;
         pa1_ff   <= pa1_in;
      end
   end

   // stage 2 logic
   always_comb begin
      alpha2 = pa1_ff[ALPHA_SH +: 7];
      a2     = greg1_ff ? 23'(z1_ff + 23'(alpha2) + 23'd1 - 23'(alpha2[6:2])) : z1_ff;
      b2_in  = 23'(a2 + B_OFS);
      xc2_in = 27'(27'(b2_in) * 27'd20 - C_OFS);
      w2_in  = 24'(z1_ff) + 24'd1;
      pw2_in = 49'(w2_in) * 49'(W_MUL);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         b2_ff   <= b2_in;
         xc2_ff  <= xc2_in;
         w2_ff   <= w2_in;
         pw2_ff  <= pw2_in;
         err2_ff <= err1_ff;
      end
   end

   // stage 3 logic
   assign pc3_in = 55'(xc2_ff) * 55'(C_MUL);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         b3_ff   <= b2_ff;
         pc3_ff  <= pc3_in;
         w3_ff   <= w2_ff;
         pw3_ff  <= pw2_ff;
         err3_ff <= err2_ff;
      end
   end

   // stage 4 logic
   always_comb begin
      c4_in  = pc3_ff[C_SH +: 15];
      d4     = 23'((26'(c4_in) * 26'd1461) >> 2);
      bd4_in = 10'(b3_ff - d4);
      wq4    = pw3_ff[W_SH +: 22];
      wd4_in = 3'(w3_ff - 24'(wq4) * 24'd7);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         c4_ff   <= c4_in;
         bd4_ff  <= bd4_in;
         wd4_ff  <= wd4_in;
         err4_ff <= err3_ff;
      end
   end

   // stage 5 logic
   assign pe5_in = 49'(bd4_ff) * 49'(E_MUL);

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         c5_ff   <= c4_ff;
         bd5_ff  <= bd4_ff;
         pe5_ff  <= pe5_in;
         wd5_ff  <= wd4_ff;
         err5_ff <= err4_ff;
      end
   end

   // stage 6 logic: month code fourteen or fifteen wraps to january or february
   always_comb begin
      e6        = pe5_ff[E_SH +: 4];
      day6      = bd5_ff - 10'(e_offset(e6));
      day6_in   = day6[DAY_W-1:0];
      month6_in = (e6 < 4'd14) ? e6 - 4'd1 : e6 - 4'd13;
      year6_in  = (month6_in > 4'd2) ? 14'(c5_ff - 15'd4716) : 14'(c5_ff - 15'd4715);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         year6_ff  <= year6_in;
         month6_ff <= month6_in;
         day6_ff   <= day6_in;
         wd6_ff    <= wd5_ff;
         err6_ff   <= err5_ff;
      end
   end

   // stage 7 logic
   assign py7_in = 29'(year6_ff) * 29'(Y_MUL);

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         year7_ff  <= year6_ff;
         month7_ff <= month6_ff;
         day7_ff   <= day6_ff;
         wd7_ff    <= wd6_ff;
         py7_ff    <= py7_in;
         err7_ff   <= err6_ff;
      end
   end

   // stage 8 logic: leap year, ordinal day, zero the fields when out of range
   always_comb begin
      q25_8   = py7_ff[Y_SH +: 10];
      div25_8 = (year7_ff == 14'(14'(q25_8) * 14'd25));
      leap8   = (year7_ff[1:0] == 2'b00) && (!div25_8 || (year7_ff[3:0] == 4'b0000));
      ord8    = days_before(month7_ff) + 9'(day7_ff)
                + 9'(leap8 && (month7_ff > 4'd2));
      year8_in  = err7_ff ? '0 : year7_ff;
      month8_in = err7_ff ? '0 : month7_ff;
      day8_in   = err7_ff ? '0 : day7_ff;
      wd8_in    = err7_ff ? '0 : wd7_ff;
      ord8_in   = err7_ff ? '0 : ord8;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[8]) begin
         year8_ff  <= year8_in;
         month8_ff <= month8_in;
         day8_ff   <= day8_in;
         wd8_ff    <= wd8_in;
         ord8_ff   <= ord8_in;
         err8_ff   <= err7_ff;
      end
   end

   // result channel
   assign rsp_chan.valid       = ctl.valid[NSTAGE-1];
   assign rsp_chan.cal_year    = year8_ff;
   assign rsp_chan.cal_month   = month8_ff;
   assign rsp_chan.cal_day     = day8_ff;
   assign rsp_chan.weekday     = wd8_ff;
   assign rsp_chan.ordinal_day = ord8_ff;
   assign rsp_chan.range_error = err8_ff;

`ifndef SYNTHESIS
   // a flagged item carries no date
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.range_error |->
         rsp_chan.cal_year == '0 && rsp_chan.cal_month == '0 && rsp_chan.cal_day == '0 &&
         rsp_chan.weekday == '0 && rsp_chan.ordinal_day == '0)
      else $error("range error item carries nonzero fields");

   // an accepted day number yields a well formed date
   a_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.range_error |->
         rsp_chan.cal_month >= 4'd1 && rsp_chan.cal_month <= 4'd12 &&
         rsp_chan.cal_day >= 5'd1 && rsp_chan.weekday <= 3'd6 &&
         rsp_chan.ordinal_day >= 9'd1 && rsp_chan.ordinal_day <= 9'd366)
      else $error("date fields out of range");

   // input back-pressure only when the pipeline is full and the output stalls
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready && (&ctl.valid))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
